// File: rtl/core/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and constants for the bit-stuffing / pulse-width line encoder.
// ----------------------------------------------------------------------------
package ble_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned DUR_W    = 20;
   localparam int unsigned MULT_W   = 4;
   localparam int unsigned BITCNT_W = 4;
   localparam int unsigned STUFF_W  = 3;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_PROTOCOL_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_INVERTED  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_SAMPLES = 2'd2;

   localparam logic MODE_PULSE   = 1'b0;
   localparam logic MODE_STUFFED = 1'b1;

   localparam logic [MULT_W-1:0] PER_ONE   = 4'd1;
   localparam logic [MULT_W-1:0] PER_TWO   = 4'd2;
   localparam logic [MULT_W-1:0] PER_THREE = 4'd3;
   localparam logic [MULT_W-1:0] PER_TEN   = 4'd10;

   localparam logic [STUFF_W-1:0] STUFF_RELOAD = 3'd4;

   localparam logic [BITCNT_W-1:0] BITS_FULL         = 4'd8;
   localparam logic [BITCNT_W-1:0] BITS_FIRST_PULSE  = 4'd2;
   localparam logic [BITCNT_W-1:0] BITS_FIRST_STUFF  = 4'd3;

   // one line segment before scaling to samples
   typedef struct packed {
      logic              dominant;
      logic [MULT_W-1:0] periods;
      logic              last;
   } seg_type;

endpackage

// File: rtl/core/ble_scale.sv
// ----------------------------------------------------------------------------
// ble_scale
// Segment scaler: maps level to line polarity and periods to samples.
// ----------------------------------------------------------------------------
module ble_scale (
   input  ble_pkg::seg_type                  seg,
   input  logic                              line_inverted,
   input  logic [ble_pkg::PERIOD_W-1:0]      period_samples,
   output logic                              line_high,
   output logic [ble_pkg::DUR_W-1:0]         duration_samples,
   output logic                              end_of_run
);

   assign line_high        = line_inverted ? seg.dominant : ~seg.dominant;
   assign duration_samples = ble_pkg::DUR_W'(seg.periods) *
                             ble_pkg::DUR_W'(period_samples);
   assign end_of_run       = seg.last;

endmodule

// File: rtl/core/ble_seq.sv
// ----------------------------------------------------------------------------
// ble_seq
// Segment sequencer: walks the frame start, data bits, stuff and end periods,
// one segment per step.
// ----------------------------------------------------------------------------
module ble_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ble_pkg::BYTE_W-1:0]        data_byte,
   input  logic                              first_byte,
   input  logic                              last_byte,
   input  logic                              protocol_mode,
   input  logic                              out_ready,
   output logic                              busy,
   output logic                              seg_valid,
   output ble_pkg::seg_type                  seg
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PRE   = 7'b0000010,
      S_START = 7'b0000100,
      S_LOW   = 7'b0001000,
      S_HIGH  = 7'b0010000,
      S_BIT   = 7'b0100000,
      S_END   = 7'b1000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [ble_pkg::BYTE_W-1:0]        data_ff, data_in;
   logic [ble_pkg::BITCNT_W-1:0]      bits_ff, bits_in;
   logic                              dom_ff, dom_in;
   logic [ble_pkg::STUFF_W-1:0]       sc_ff, sc_in;
   logic                              mode_ff, mode_in;
   logic                              last_ff, last_in;
   logic                              step;

   assign busy      = (state_ff != S_IDLE);
   assign seg_valid = busy;
   assign step      = busy & out_ready;

   always_comb begin
      logic                         nd;
      logic [ble_pkg::STUFF_W-1:0]  nsc;
      logic                         consume;
      logic [ble_pkg::BITCNT_W-1:0] bits_dec;
      logic [ble_pkg::BITCNT_W-1:0] nbits;
      logic                         done;

      state_in = state_ff;
      data_in  = data_ff;
      bits_in  = bits_ff;
      dom_in   = dom_ff;
      sc_in    = sc_ff;
      mode_in  = mode_ff;
      last_in  = last_ff;
      seg      = '0;
      bits_dec = bits_ff - 1'b1;
      nd       = dom_ff;
      nsc      = sc_ff;
      consume  = 1'b0;
      nbits    = bits_ff;
      done     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = protocol_mode;
               last_in = last_byte;
               if (protocol_mode == ble_pkg::MODE_PULSE) begin
                  dom_in = 1'b0;
                  if (first_byte) begin
                     data_in  = data_byte << 6;
                     bits_in  = ble_pkg::BITS_FIRST_PULSE;
                     state_in = S_PRE;
                  end else begin
                     data_in  = data_byte;
                     bits_in  = ble_pkg::BITS_FULL;
                     state_in = S_LOW;
                  end
               end else begin
                  if (first_byte) begin
                     dom_in   = 1'b0;
                     sc_in    = '0;
                     data_in  = data_byte << 5;
                     bits_in  = ble_pkg::BITS_FIRST_STUFF;
                     state_in = S_START;
                  end else begin
                     data_in  = data_byte;
                     bits_in  = ble_pkg::BITS_FULL;
                     state_in = S_BIT;
                  end
               end
            end
         end
         S_PRE: begin
            seg = '{dominant: 1'b0, periods: ble_pkg::PER_TWO, last: 1'b0};
            if (step) state_in = S_START;
         end
         S_START: begin
            if (mode_ff == ble_pkg::MODE_STUFFED) begin
               seg = '{dominant: 1'b0, periods: ble_pkg::PER_TEN, last: 1'b0};
               if (step) state_in = S_BIT;
            end else begin
               seg = '{dominant: 1'b1, periods: ble_pkg::PER_TEN, last: 1'b0};
               if (step) state_in = S_LOW;
            end
         end
         S_LOW: begin
            seg = '{dominant: 1'b0, periods: ble_pkg::PER_ONE, last: 1'b0};
            if (step) state_in = S_HIGH;
         end
         S_HIGH: begin
            seg = '{dominant: 1'b1,
                    periods:  data_ff[ble_pkg::BYTE_W-1] ? ble_pkg::PER_THREE
                                                         : ble_pkg::PER_ONE,
                    last:     (bits_dec == '0)};
            if (step) begin
               data_in  = data_ff << 1;
               bits_in  = bits_dec;
               state_in = (bits_dec == '0) ? S_IDLE : S_LOW;
            end
         end
         S_BIT: begin
            if (sc_ff == '0) begin
               nd      = ~dom_ff;
               nsc     = ble_pkg::STUFF_RELOAD;
               consume = 1'b0;
            end else if (data_ff[ble_pkg::BYTE_W-1] != dom_ff) begin
               nd      = data_ff[ble_pkg::BYTE_W-1];
               nsc     = ble_pkg::STUFF_RELOAD;
               consume = 1'b1;
            end else begin
               nd      = dom_ff;
               nsc     = sc_ff - 1'b1;
               consume = 1'b1;
            end
            nbits = consume ? bits_dec : bits_ff;
            done  = (nbits == '0);
            seg   = '{dominant: nd, periods: ble_pkg::PER_ONE,
                      last: done & ~(last_ff & ~nd)};
            if (step) begin
               dom_in = (done & last_ff) ? 1'b0 : nd;
               sc_in  = nsc;
               if (consume) begin
                  data_in = data_ff << 1;
                  bits_in = bits_dec;
               end
               if (done) state_in = (last_ff & ~nd) ? S_END : S_IDLE;
            end
         end
         S_END: begin
            seg = '{dominant: 1'b1, periods: ble_pkg::PER_ONE, last: 1'b1};
            if (step) begin
               dom_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dom_ff   <= 1'b0;
         sc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         dom_ff   <= dom_in;
         sc_ff    <= sc_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      bits_ff <= bits_in;
      mode_ff <= mode_in;
      last_ff <= last_in;
   end

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("sequencer did not leave idle on a new word");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (step && seg.last) |=> !busy)
      else $error("sequencer still busy after last segment");

   a_stuff_range: assert property (@(posedge clock) disable iff (reset)
      sc_ff <= ble_pkg::STUFF_RELOAD)
      else $error("stuff count out of range");

   a_bits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BIT || state_ff == S_HIGH) |-> (bits_ff != '0))
      else $error("bit state entered with no bits left");
`endif

endmodule

// File: rtl/core/bus_line_encoder_pwm_or_bitstuff_core.sv
// ----------------------------------------------------------------------------
// bus_line_encoder_pwm_or_bitstuff_core
// Line encoder: packet bytes in, line segments (level, duration) out, in
// pulse-width or bit-stuffed NRZ coding.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | data_byte, first_byte, last_byte
//   rsp     | out       | rsp_valid/stall    | line_high, duration_samples,
//           |           |                    | end_of_run
//   csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
// One word is loaded while the sequencer is idle; the segment sequencer then
// sets the pace, one segment per step (up to 16 segments in pulse mode, up
// to 11 in stuffed mode). Synchronous reset clears the sequencer state, line
// state and rsp_valid and loads the CSR defaults.
// A stalled rsp holds the sequencer; req is stalled while a word is in work.
// ----------------------------------------------------------------------------
module bus_line_encoder_pwm_or_bitstuff_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ble_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                               req_first_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_line_high,
   output logic [ble_pkg::DUR_W-1:0]          rsp_duration_samples,
   output logic                               rsp_end_of_run,
   input  logic                               csr_write_enable,
   input  logic [ble_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ble_pkg::PERIOD_W-1:0]       csr_write_data
);

   logic                              mode_ff, mode_in;
   logic                              inv_ff, inv_in;
   logic [ble_pkg::PERIOD_W-1:0]      period_ff, period_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              line_high_ff;
   logic [ble_pkg::DUR_W-1:0]         dur_ff;
   logic                              eor_ff;

   logic                              busy;
   logic                              seg_valid;
   ble_pkg::seg_type                  seg;
   logic                              out_ready;
   logic                              start;
   logic                              sc_line_high;
   logic [ble_pkg::DUR_W-1:0]         sc_dur;
   logic                              sc_eor;

   assign req_stall = busy;
   assign start     = req_valid & ~busy;
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      mode_in   = mode_ff;
      inv_in    = inv_ff;
      period_in = period_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ble_pkg::CSR_PROTOCOL_MODE:  mode_in   = csr_write_data[0];
            ble_pkg::CSR_LINE_INVERTED:  inv_in    = csr_write_data[0];
            ble_pkg::CSR_PERIOD_SAMPLES: period_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ble_pkg::MODE_PULSE;
         inv_ff    <= 1'b0;
         period_ff <= ble_pkg::PERIOD_RESET;
      end else begin
         mode_ff   <= mode_in;
         inv_ff    <= inv_in;
         period_ff <= period_in;
      end
   end

   ble_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .data_byte     (req_data_byte),
      .first_byte    (req_first_byte),
      .last_byte     (req_last_byte),
      .protocol_mode (mode_ff),
      .out_ready     (out_ready),
      .busy          (busy),
      .seg_valid     (seg_valid),
      .seg           (seg)
   );

   ble_scale u_scale (
      .seg              (seg),
      .line_inverted    (inv_ff),
      .period_samples   (period_ff),
      .line_high        (sc_line_high),
      .duration_samples (sc_dur),
      .end_of_run       (sc_eor)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (seg_valid && out_ready) rsp_valid_in = 1'b1;
      else if (!rsp_stall)        rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (seg_valid && out_ready) begin
         line_high_ff <= sc_line_high;
         dur_ff       <= sc_dur;
         eor_ff       <= sc_eor;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_line_high        = line_high_ff;
   assign rsp_duration_samples = dur_ff;
   assign rsp_end_of_run       = eor_ff;

endmodule

// File: tb/tb_bus_line_encoder_pwm_or_bitstuff_core.sv
// ----------------------------------------------------------------------------
// tb_bus_line_encoder_pwm_or_bitstuff_core
// Self-checking bench for the line encoder. A directed table covers reset
// values, duration extremes, both codings, stuffing, reopened packets and
// mode changes mid-packet. It is followed by random packets under changing
// register settings. Every accepted word is run through a behavioral encoder
// that queues the expected line segments. Every accepted segment is compared
// with the oldest queued one. req idles and rsp stalls at random.
// ----------------------------------------------------------------------------
module tb_bus_line_encoder_pwm_or_bitstuff_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned RANDOM_WORDS = 128;
   localparam int unsigned TAIL_CYCLES  = 20;

   typedef struct packed {
      logic                      line_high;
      logic [ble_pkg::DUR_W-1:0] dur;
      logic                      eor;
   } segment_type;

   typedef enum logic {ROW_CFG, ROW_WORD} row_kind_type;

   typedef struct {
      row_kind_type                 kind;
      logic                         mode;
      logic                         inv;
      logic [ble_pkg::PERIOD_W-1:0] period;
      logic [ble_pkg::BYTE_W-1:0]   data;
      logic                         first;
      logic                         last;
      int unsigned                  n_segs;
      logic                         seg0_high;
      logic [ble_pkg::DUR_W-1:0]    seg0_dur;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [ble_pkg::BYTE_W-1:0]    req_data_byte = '0;
   logic                          req_first_byte = 1'b0;
   logic                          req_last_byte = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_line_high;
   logic [ble_pkg::DUR_W-1:0]     rsp_duration_samples;
   logic                          rsp_end_of_run;
   logic                          csr_write_enable = 1'b0;
   logic [ble_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ble_pkg::PERIOD_W-1:0]  csr_write_data = '0;

   // encoder model state
   logic                         mode_r   = ble_pkg::MODE_PULSE;
   logic                         inv_r    = 1'b0;
   logic [ble_pkg::PERIOD_W-1:0] period_r = ble_pkg::PERIOD_RESET;
   logic                         dom_r    = 1'b0;
   logic [ble_pkg::STUFF_W-1:0]  stuff_r  = '0;

   segment_type seg_q[$];
   int unsigned last_n;
   segment_type last_first;
   int unsigned errors = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned stall_left = 0;
   int unsigned stall_style = 0;
   int unsigned cyc = 0;

   bus_line_encoder_pwm_or_bitstuff_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_first_byte       (req_first_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_line_high        (rsp_line_high),
      .rsp_duration_samples (rsp_duration_samples),
      .rsp_end_of_run       (rsp_end_of_run),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   function automatic segment_type line_segment(input logic dom,
                                                input int unsigned periods);
      segment_type s;
      s.line_high = inv_r ? dom : ~dom;
      s.dur       = ble_pkg::DUR_W'(periods * period_r);
      s.eor       = 1'b0;
      return s;
   endfunction

   task automatic encode_word(input logic [ble_pkg::BYTE_W-1:0] b, input logic f,
                              input logic l);
      segment_type                run[$];
      logic [ble_pkg::BYTE_W-1:0] mask;
      logic                       bit_one;
      if (mode_r == ble_pkg::MODE_PULSE) begin
         if (f) begin
            run.push_back(line_segment(1'b0, ble_pkg::PER_TWO));
            run.push_back(line_segment(1'b1, ble_pkg::PER_TEN));
         end
         mask = f ? 8'h02 : 8'h80;
         while (mask != 0) begin
            run.push_back(line_segment(1'b0, ble_pkg::PER_ONE));
            run.push_back(line_segment(1'b1, (b & mask) != 0 ? ble_pkg::PER_THREE
                                                             : ble_pkg::PER_ONE));
            mask >>= 1;
         end
         dom_r = 1'b0;
      end else begin
         if (f) begin
            dom_r   = 1'b0;
            stuff_r = '0;
            run.push_back(line_segment(1'b0, ble_pkg::PER_TEN));
         end
         mask = f ? 8'h04 : 8'h80;
         while (mask != 0) begin
            if (stuff_r == 0) begin
               // forced transition, the data bit waits
               dom_r   = ~dom_r;
               stuff_r = ble_pkg::STUFF_RELOAD;
            end else begin
               bit_one = (b & mask) != 0;
               if (bit_one != dom_r) begin
                  dom_r   = bit_one;
                  stuff_r = ble_pkg::STUFF_RELOAD;
               end else begin
                  stuff_r = stuff_r - 1'b1;
               end
               mask >>= 1;
            end
            run.push_back(line_segment(dom_r, ble_pkg::PER_ONE));
         end
         if (l) begin
            if (!dom_r) run.push_back(line_segment(1'b1, ble_pkg::PER_ONE));
            dom_r = 1'b0;
         end
      end
      run[run.size()-1].eor = 1'b1;
      last_n     = run.size();
      last_first = run[0];
      foreach (run[i]) seg_q.push_back(run[i]);
   endtask

   always @(posedge clock) begin : rsp_check
      segment_type want;
      logic        moved;
      if (!reset) begin
         cyc++;
         moved = csr_write_enable;
         if (csr_write_enable) begin
            case (csr_index)
               ble_pkg::CSR_PROTOCOL_MODE:  mode_r   = csr_write_data[0];
               ble_pkg::CSR_LINE_INVERTED:  inv_r    = csr_write_data[0];
               ble_pkg::CSR_PERIOD_SAMPLES: period_r = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            encode_word(req_data_byte, req_first_byte, req_last_byte);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (seg_q.size() == 0) begin
               report_mismatch("segment with nothing expected", rsp_duration_samples, 0);
            end else begin
               want = seg_q.pop_front();
               if (rsp_line_high !== want.line_high)
                  report_mismatch("line_high", rsp_line_high, want.line_high);
               if (rsp_duration_samples !== want.dur)
                  report_mismatch("duration_samples", rsp_duration_samples, want.dur);
               if (rsp_end_of_run !== want.eor)
                  report_mismatch("end_of_run", rsp_end_of_run, want.eor);
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_bus_line_encoder_pwm_or_bitstuff_core failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = $urandom_range(10, 60);
      end
      stall_left--;
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         2: rsp_stall <= (cyc % 3 == 0);
         default: rsp_stall <= ($urandom_range(0, 99) < 80);
      endcase
   end

   task automatic send_word(input logic [ble_pkg::BYTE_W-1:0] b, input logic f,
                            input logic l);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap        = $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_first_byte <= f;
      req_last_byte  <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // called at a falling edge with req_valid possibly still high
   task automatic program_regs(input logic mode, input logic inv,
                               input logic [ble_pkg::PERIOD_W-1:0] period);
      req_valid <= 1'b0;
      while (seg_q.size() != 0) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= ble_pkg::CSR_PROTOCOL_MODE;
      csr_write_data   <= ble_pkg::PERIOD_W'(mode);
      @(negedge clock);
      csr_index        <= ble_pkg::CSR_LINE_INVERTED;
      csr_write_data   <= ble_pkg::PERIOD_W'(inv);
      @(negedge clock);
      csr_index        <= ble_pkg::CSR_PERIOD_SAMPLES;
      csr_write_data   <= period;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic stim_row_type cfg_row(input logic mode, input logic inv,
                                            input logic [ble_pkg::PERIOD_W-1:0] period);
      stim_row_type r;
      r        = '{kind: ROW_CFG, default: '0};
      r.mode   = mode;
      r.inv    = inv;
      r.period = period;
      return r;
   endfunction

   function automatic stim_row_type word_row(input logic [ble_pkg::BYTE_W-1:0] b,
                                             input logic f, input logic l,
                                             input int unsigned n, input logic hi,
                                             input logic [ble_pkg::DUR_W-1:0] dur);
      stim_row_type r;
      r           = '{kind: ROW_WORD, default: '0};
      r.data      = b;
      r.first     = f;
      r.last      = l;
      r.n_segs    = n;
      r.seg0_high = hi;
      r.seg0_dur  = dur;
      return r;
   endfunction

   initial begin
      stim_row_type                 plan[$];
      int unsigned                  sent;
      int unsigned                  next_cfg;
      int unsigned                  len;
      logic [ble_pkg::PERIOD_W-1:0] period;

      // n_segs of 0: the row is checked against the encoder model only
      plan.push_back(word_row(8'h00, 1, 0, 6, 1'b1, 200));
      plan.push_back(word_row(8'hFF, 0, 0, 16, 1'b1, 100));
      plan.push_back(word_row(8'h00, 0, 1, 16, 1'b1, 100));
      plan.push_back(word_row(8'hA5, 0, 0, 0, 1'b0, 0));
      plan.push_back(word_row(8'hFF, 1, 1, 6, 1'b1, 200));
      plan.push_back(cfg_row(ble_pkg::MODE_PULSE, 1'b1, 16'd1));
      plan.push_back(word_row(8'hFE, 1, 0, 6, 1'b0, 2));
      plan.push_back(word_row(8'h55, 0, 1, 16, 1'b0, 1));
      plan.push_back(cfg_row(ble_pkg::MODE_PULSE, 1'b0, 16'hFFFF));
      plan.push_back(word_row(8'h03, 1, 1, 6, 1'b1, 131070));
      plan.push_back(word_row(8'h80, 0, 0, 16, 1'b1, 65535));
      plan.push_back(cfg_row(ble_pkg::MODE_STUFFED, 1'b0, 16'd100));
      plan.push_back(word_row(8'h00, 1, 1, 6, 1'b1, 1000));
      plan.push_back(word_row(8'h07, 1, 0, 5, 1'b1, 1000));
      plan.push_back(word_row(8'hFF, 0, 0, 0, 1'b0, 0));
      plan.push_back(word_row(8'hFF, 0, 1, 0, 1'b0, 0));
      plan.push_back(word_row(8'h05, 1, 0, 0, 1'b0, 0));
      plan.push_back(word_row(8'h02, 1, 0, 0, 1'b0, 0));
      plan.push_back(word_row(8'hAA, 0, 1, 0, 1'b0, 0));
      plan.push_back(cfg_row(ble_pkg::MODE_STUFFED, 1'b1, 16'hFFFF));
      plan.push_back(word_row(8'h00, 1, 1, 6, 1'b0, 655350));
      plan.push_back(word_row(8'hF7, 1, 0, 0, 1'b0, 0));
      plan.push_back(word_row(8'hF0, 0, 0, 0, 1'b0, 0));
      plan.push_back(cfg_row(ble_pkg::MODE_PULSE, 1'b0, 16'd7));
      plan.push_back(word_row(8'h3C, 0, 0, 0, 1'b0, 0));
      plan.push_back(cfg_row(ble_pkg::MODE_STUFFED, 1'b0, 16'd7));
      plan.push_back(word_row(8'h81, 0, 1, 0, 1'b0, 0));
      plan.push_back(word_row(8'h1F, 1, 1, 0, 1'b0, 0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            program_regs(plan[i].mode, plan[i].inv, plan[i].period);
         end else begin
            send_word(plan[i].data, plan[i].first, plan[i].last);
            if (plan[i].n_segs != 0) begin
               if (last_n != plan[i].n_segs)
                  report_mismatch("segment count", last_n, plan[i].n_segs);
               if (last_first.line_high !== plan[i].seg0_high)
                  report_mismatch("opening line_high", last_first.line_high,
                                  plan[i].seg0_high);
               if (last_first.dur !== plan[i].seg0_dur)
                  report_mismatch("opening duration", last_first.dur, plan[i].seg0_dur);
            end
         end
      end

      sent     = 0;
      next_cfg = 0;
      while (sent < RANDOM_WORDS) begin
         if (sent >= next_cfg) begin
            case ($urandom_range(0, 3))
               0: period = 16'd1;
               1: period = 16'hFFFF;
               2: period = ble_pkg::PERIOD_W'($urandom_range(1, 20));
               default: period = ble_pkg::PERIOD_W'($urandom_range(1, 65535));
            endcase
            program_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), period);
            next_cfg = sent + $urandom_range(15, 35);
         end
         if ($urandom_range(0, 9) < 8) begin
            len = $urandom_range(1, 6);
            for (int unsigned k = 0; k < len; k++)
               send_word(8'($urandom), k == 0, k == len - 1);
            sent += len;
         end else begin
            send_word(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (seg_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb_bus_line_encoder_pwm_or_bitstuff_core passed");
      else
         $display("tb_bus_line_encoder_pwm_or_bitstuff_core failed");
      $finish;
   end

endmodule
